/* hdl/itd_pkg.sv */
// itd_pkg: shared types and character/register constants for the integer-to-decimal-text block.
// No dependencies; imported by int_list_to_decimal_text, itd_checker and tb_top.
`default_nettype none

package itd_pkg;

	typedef logic [7:0]  char_t;
	typedef logic [11:0] count_t;

	localparam char_t CHAR_MINUS = 8'h2D;
	localparam char_t CHAR_SPACE = 8'h20;
	localparam char_t CHAR_ZERO  = 8'h30;
	localparam char_t CHAR_NINE  = 8'h39;
	localparam char_t CHAR_NONE  = 8'h00;

	localparam count_t BUFFER_SIZE_RST = 12'd841;

	// register index as decoded from paddr[2]
	localparam logic REG_IDX_BUFFER_SIZE = 1'b0;

endpackage

`default_nettype wire

/* hdl/itd_dabble.sv */
// itd_dabble: iterative binary-to-BCD converter (shift and add-3), one bit per cycle.
// Depends on nothing beyond its parameters.
`default_nettype none

module itd_dabble #(
	parameter int VALUE_BITS = 32,
	parameter int DIGITS     = 10
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [VALUE_BITS-1:0]   mag,
	output logic                         done,
	output logic [4*DIGITS-1:0]          bcd
);

	localparam int CNTW = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] bin_q;
	logic [4*DIGITS-1:0]   bcd_q;
	logic [CNTW-1:0]       cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [4*DIGITS-1:0]   adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {adj[4*DIGITS-2:0], bin_q[VALUE_BITS-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

/* hdl/int_list_to_decimal_text.sv */
// int_list_to_decimal_text: formats signed integers as decimal ASCII beats with a buffer check.
// Depends on itd_pkg and itd_dabble.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+----------------------------------------------
//   s_*      | in  | s_tvalid / s_tready    | s_tdata = value, s_tuser = list_start
//   m_*      | out | m_tvalid / m_tready    | m_tdata = char_code, m_tlast = last,
//            |     |                        | m_tuser = overflow
//   APB      | in  | psel/penable/pready    | 0x0: buffer_size [11:0]
//
// Sequence: after an input beat the BCD loop shifts in one bit per cycle over all VALUE_BITS
//   bits, then ST_COUNT finds the digit count and ST_DECIDE makes the fit test; characters
//   then leave one per cycle while the receiver keeps m_tready high. An item dropped after
//   overflow is taken in ST_IDLE, which the sequencer does not leave for it.
// Reset: arst_n clears the sequencer, count, overflow latch and buffer_size (841). No
//   memory, no clearing pass.
// Stalls: the output register holds a beat until m_tready; the sequencer waits there.
//   s_tready is high only while idle; the last beat of an item may still be waiting then.
`default_nettype none

module int_list_to_decimal_text
	import itd_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,  // [VALUE_BITS-1:0] value
	input  wire logic [0:0]                        s_tuser,  // [0] list_start
	// output stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [7:0]                             m_tdata,  // [7:0] char_code
	output logic                                   m_tlast,
	output logic [0:0]                             m_tuser,  // [0] overflow
	// configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [2:0]                        paddr,
	input  wire logic [31:0]                       pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);

	// decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
	localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
	localparam int NDW    = $clog2(DIGITS + 1);
	localparam int NCW    = $clog2(DIGITS + 2);
	localparam int DIW    = $clog2(DIGITS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CONV   = 3'd1;
	localparam logic [2:0] ST_COUNT  = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0]            state_q;
	count_t                buffer_size_q;
	count_t                chars_q;
	logic                  ovf_latched_q;
	logic                  neg_q;
	logic [NDW-1:0]        nd_q;
	logic                  ovf_item_q;
	logic                  sign_pend_q;
	logic                  dig_pend_q;
	logic [DIW-1:0]        dig_q;

	logic                  out_valid_q;
	char_t                 out_char_q;
	logic                  out_last_q;
	logic                  out_ovf_q;

	logic [VALUE_BITS-1:0] value_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic                  accept;
	logic                  dab_start;
	logic                  dab_done;
	logic [4*DIGITS-1:0]   bcd;
	logic [NDW-1:0]        nd_w;
	logic [NCW-1:0]        nchars;
	logic [12:0]           fit_sum;
	logic [12:0]           fit_lim;
	logic                  fit_fail;
	logic                  out_free;
	logic                  cfg_wr;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= BUFFER_SIZE_RST;
		end else if (cfg_wr && (paddr[2] == REG_IDX_BUFFER_SIZE)) begin
			buffer_size_q <= pwdata[11:0];
		end
	end

	assign prdata = (paddr[2] == REG_IDX_BUFFER_SIZE) ? {20'd0, buffer_size_q} : 32'd0;

	// ---------------- input side ----------------
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign value_in  = s_tdata[VALUE_BITS-1:0];
	// most negative value maps onto itself, read unsigned that is its magnitude
	assign mag_in    = value_in[VALUE_BITS-1] ? (~value_in + 1'b1) : value_in;
	// a latched overflow drops the item unless it opens a new list
	assign dab_start = accept && (s_tuser[0] || !ovf_latched_q);

	itd_dabble #(
		.VALUE_BITS(VALUE_BITS),
		.DIGITS    (DIGITS)
	) u_dabble (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dab_start),
		.mag   (mag_in),
		.done  (dab_done),
		.bcd   (bcd)
	);

	// digit count: position of the highest nonzero digit, zero is one digit
	always_comb begin
		nd_w = NDW'(1);
		for (int i = 1; i < DIGITS; i++) begin
			if (bcd[4*i +: 4] != 4'd0) begin
				nd_w = NDW'(i + 1);
			end
		end
	end

	// fit test: count + nchars >= size - 1, or size zero
	assign nchars   = NCW'(nd_q) + NCW'(neg_q);
	assign fit_sum  = {1'b0, chars_q} + 13'(nchars);
	assign fit_lim  = {1'b0, buffer_size_q} - 13'd1;
	assign fit_fail = (buffer_size_q == 12'd0) || (fit_sum >= fit_lim);

	assign out_free = !out_valid_q || m_tready;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			chars_q       <= '0;
			ovf_latched_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// a new beat loads as the old one leaves
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser[0]) begin
						chars_q       <= '0;
						ovf_latched_q <= 1'b0;
					end
					if (dab_start) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (dab_done) begin
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (fit_fail) begin
						ovf_latched_q <= 1'b1;
					end else begin
						chars_q <= chars_q + 12'(nchars) + 12'd1;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (ovf_item_q || (!sign_pend_q && !dig_pend_q)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-item payload and the character selector
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= value_in[VALUE_BITS-1];
		end
		if (state_q == ST_COUNT) begin
			nd_q <= nd_w;
		end
		if (state_q == ST_DECIDE) begin
			ovf_item_q  <= fit_fail;
			sign_pend_q <= neg_q;
			dig_pend_q  <= 1'b1;
			dig_q       <= DIW'(nd_q - 1'b1);
		end
		if ((state_q == ST_EMIT) && out_free) begin
			if (ovf_item_q) begin
				out_char_q <= CHAR_NONE;
				out_last_q <= 1'b1;
				out_ovf_q  <= 1'b1;
			end else if (sign_pend_q) begin
				out_char_q  <= CHAR_MINUS;
				out_last_q  <= 1'b0;
				out_ovf_q   <= 1'b0;
				sign_pend_q <= 1'b0;
			end else if (dig_pend_q) begin
				out_char_q <= CHAR_ZERO + {4'd0, bcd[{dig_q, 2'b00} +: 4]};
				out_last_q <= 1'b0;
				out_ovf_q  <= 1'b0;
				if (dig_q == '0) begin
					dig_pend_q <= 1'b0;
				end else begin
					dig_q <= dig_q - 1'b1;
				end
			end else begin
				out_char_q <= CHAR_SPACE;
				out_last_q <= 1'b1;
				out_ovf_q  <= 1'b0;
			end
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_char_q;
	assign m_tlast    = out_last_q;
	assign m_tuser[0] = out_ovf_q;

endmodule

`default_nettype wire

/* hdl/itd_checker.sv */
// itd_checker: port-level assertions for int_list_to_decimal_text, bound to the top level.
// Depends on itd_pkg.
`default_nettype none

module itd_checker
	import itd_pkg::*;
(
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [7:0]                      m_tdata,
	input wire logic                            m_tlast,
	input wire logic [0:0]                      m_tuser
);

	// overflow beat is a lone last beat carrying a zero code
	a_ovf_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata == CHAR_NONE)))
		else $error("overflow beat not last or nonzero");

	// a normal beat is a sign, a digit or the trailing space
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |->
		((m_tdata == CHAR_MINUS) || (m_tdata == CHAR_SPACE) ||
		 ((m_tdata >= CHAR_ZERO) && (m_tdata <= CHAR_NINE))))
		else $error("bad character code");

	// space only closes an item
	a_space_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tlast == (m_tdata == CHAR_SPACE)))
		else $error("tlast does not match the space");

	// no new item taken while a number is still being sent
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !s_tready)
		else $error("input ready in the middle of a number");

	// stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=>
		(m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
		else $error("stalled output beat changed");

endmodule

bind int_list_to_decimal_text itd_checker u_itd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

`default_nettype wire

/* sim/tb_top.sv */
// tb_top: self-checking bench for int_list_to_decimal_text; streams signed integers in,
// predicts the decimal character beats and checks every output beat against them.
// Depends on itd_pkg and the block's RTL; reconfigures buffer_size over APB between batches.
`default_nettype none

module tb_top;
	import itd_pkg::*;

	localparam int VALUE_BITS     = 32;
	localparam int WATCHDOG_LIMIT = 2000; // quiet cycles before the run is declared hung
	localparam int SETTLE_CYCLES  = 64;   // longer than one item when the receiver does not stall
	localparam int MAX_REPORTS    = 10;
	localparam int BATCH_LEN      = 40;
	localparam int TARGET_ITEMS   = 330;  // the run stops once this many numbers were taken (directed plus random)
	localparam logic [2:0] ADDR_BUFFER_SIZE = {REG_IDX_BUFFER_SIZE, 2'b00};

	// one number waiting to go out on the input stream
	typedef struct {
		logic [31:0] value;
		logic        start;
	} num_item_t;

	// one predicted output beat
	typedef struct {
		char_t code;
		logic  last;
		logic  ovf;
	} text_beat_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;  // [31:0] value
	logic [0:0]  s_tuser  = '0;  // [0] list_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [7:0] char_code
	logic        m_tlast;
	logic [0:0]  m_tuser;        // [0] overflow
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	num_item_t  num_q [$];   // numbers not yet accepted by the block
	text_beat_t char_q [$];  // characters predicted but not yet seen

	// shadow copy of the formatter state
	count_t fmt_cap     = BUFFER_SIZE_RST;
	count_t fmt_count   = '0;
	logic   fmt_stopped = 1'b0;

	int send_idle = 34;  // percent of free cycles the sender holds back
	int recv_idle = 47;  // percent of cycles the receiver stalls
	logic in_taken = 1'b0;
	int   quiet_cycles = 0;

	int n_bad       = 0;
	int n_formatted = 0;
	int n_dropped   = 0;
	int n_overflows = 0;
	int n_chars     = 0;
	int n_settings  = 0;

	int_list_to_decimal_text #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Predicts the beats for one accepted number and updates the shadow state.
	task automatic format_number(input logic [31:0] value, input logic start);
		logic        neg;
		logic [31:0] mag;
		char_t       digs [0:11];
		int          nd;
		int          nchars;
		text_beat_t  b;
		if (start) begin
			fmt_count   = '0;
			fmt_stopped = 1'b0;
		end
		if (fmt_stopped) begin
			// list already overflowed: number is swallowed, no beats
			n_dropped++;
		end else begin
			neg = value[31];
			mag = neg ? (~value + 32'd1) : value;
			nd  = 0;
			// digits, least significant first; most negative value works as unsigned
			do begin
				digs[nd] = CHAR_ZERO + char_t'(mag % 32'd10);
				mag      = mag / 32'd10;
				nd++;
			end while (mag != 0);
			nchars = nd + (neg ? 1 : 0);
			if (fmt_cap == 0 || int'(fmt_count) + nchars >= int'(fmt_cap) - 1) begin
				// would not fit (or no room at all): single overflow beat, count untouched
				fmt_stopped = 1'b1;
				b = '{code: CHAR_NONE, last: 1'b1, ovf: 1'b1};
				char_q.push_back(b);
				n_overflows++;
			end else begin
				if (neg) begin
					b = '{code: CHAR_MINUS, last: 1'b0, ovf: 1'b0};
					char_q.push_back(b);
				end
				for (int i = nd - 1; i >= 0; i--) begin
					b = '{code: digs[i], last: 1'b0, ovf: 1'b0};
					char_q.push_back(b);
				end
				b = '{code: CHAR_SPACE, last: 1'b1, ovf: 1'b0};
				char_q.push_back(b);
				fmt_count = count_t'(int'(fmt_count) + nchars + 1);
			end
			n_formatted++;
		end
	endtask

	// Random value with a spread over digit counts, powers of ten and the extremes.
	function automatic logic [31:0] pick_value();
		int unsigned k;
		int unsigned lo;
		int unsigned hi;
		int unsigned p;
		logic [31:0] v;
		p = 1;
		case ($urandom_range(4, 0))
			0: v = $urandom;
			1: v = $urandom_range(9, 0);
			2: begin
				k = $urandom_range(10, 1);
				for (int i = 1; i < k; i++) p = p * 10;
				lo = (k == 1) ? 0 : p;
				hi = (k == 10) ? 32'h7FFF_FFFF : p * 10 - 1;
				v  = $urandom_range(hi, lo);
			end
			3: begin
				// right at a power of ten or one below it
				k = $urandom_range(9, 1);
				for (int i = 0; i < k; i++) p = p * 10;
				v = p - $urandom_range(1, 0);
			end
			default: begin
				case ($urandom_range(3, 0))
					0: v = 32'h0000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h8000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
		endcase
		if (v != 32'h8000_0000 && $urandom_range(1, 0) == 1) v = -v;
		return v;
	endfunction

	task automatic push_num(input logic [31:0] value, input logic start);
		num_item_t it;
		it = '{value: value, start: start};
		num_q.push_back(it);
	endtask

	// Sender holds off until every predicted beat is back, then lets the block settle,
	// since a swallowed number leaves no beat to wait for.
	task automatic wait_idle();
		while (num_q.size() != 0 || char_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// APB write of buffer_size (junk in the upper bits), then a read-back check.
	task automatic set_capacity(input int cap);
		logic [31:0] wdata;
		logic [31:0] rdata;
		wdata = {$urandom} & 32'hFFFF_F000 | (32'(cap) & 32'h0000_0FFF);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BUFFER_SIZE;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		fmt_cap = count_t'(wdata[11:0]);
		n_settings++;
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rdata != {20'b0, fmt_cap}) begin
			n_bad++;
			if (n_bad <= MAX_REPORTS)
				$display("buffer_size read-back: expected %0d, got %0d", fmt_cap, rdata);
		end
	endtask

	// Input driver: presents the head of num_q; the monitor pops it on acceptance.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (num_q.size() != 0 && $urandom_range(99, 0) >= send_idle) begin
				s_tvalid <= 1'b1;
				s_tdata  <= num_q[0].value;
				s_tuser  <= num_q[0].start;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99, 0) >= recv_idle);
	end

	// Monitor: checks output beats, predicts on input beats, watches for a hang.
	always @(posedge clk) begin : mon
		text_beat_t want;
		logic       moved;
		moved = 1'b0;
		if (m_tvalid && m_tready) begin
			moved = 1'b1;
			if (char_q.size() == 0) begin
				n_bad++;
				if (n_bad <= MAX_REPORTS)
					$display("unexpected beat: char %h last %b ovf %b",
						m_tdata, m_tlast, m_tuser[0]);
			end else begin
				want = char_q.pop_front();
				n_chars++;
				if (m_tdata != want.code || m_tlast != want.last || m_tuser[0] != want.ovf) begin
					n_bad++;
					if (n_bad <= MAX_REPORTS)
						$display("beat mismatch: expected char %h last %b ovf %b, got %h %b %b",
							want.code, want.last, want.ovf, m_tdata, m_tlast, m_tuser[0]);
				end
			end
		end
		if (s_tvalid && s_tready && arst_n) begin
			moved = 1'b1;
			format_number(s_tdata, s_tuser[0]);
			void'(num_q.pop_front());
		end
		in_taken <= s_tvalid && s_tready && arst_n;
		if (moved) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Stimulus sequencer.
	initial begin : stim
		int caps [10];
		int cap;
		int start_pct;
		int batch;
		caps  = '{4095, 841, 40, 1, 120, 2, 25, 600, 13, 300};
		batch = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset capacity (841), and the first numbers carry no list start:
		// they continue the list opened by reset.
		push_num(32'd0, 1'b0);
		push_num(32'hFFFF_FFFF, 1'b0);
		push_num(32'd1, 1'b0);
		push_num(32'h7FFF_FFFF, 1'b0);
		push_num(32'h8000_0000, 1'b0);
		push_num(32'd9, 1'b0);
		push_num(32'd10, 1'b0);
		push_num(-32'd10, 1'b0);
		push_num(32'd999999999, 1'b0);
		push_num(32'd1000000000, 1'b0);
		push_num(-32'd1000000000, 1'b1);
		push_num(32'd100, 1'b0);
		wait_idle();

		// Zero capacity: every list overflows at once, followers are swallowed.
		set_capacity(0);
		push_num(32'd5, 1'b1);
		push_num(-32'd7, 1'b0);
		push_num(32'd0, 1'b1);
		push_num(32'h8000_0000, 1'b0);
		wait_idle();

		// Small buffer: fill up, overflow, swallow, then restart the list.
		set_capacity(14);
		push_num(32'd123456789, 1'b1);
		push_num(32'd5, 1'b0);
		push_num(32'd7, 1'b0);
		push_num(32'd8, 1'b0);
		push_num(32'h8000_0000, 1'b1);
		push_num(-32'd42, 1'b1);
		wait_idle();

		// Fit boundary: ten characters just fit in 12, eleven do not.
		set_capacity(12);
		push_num(-32'd123456789, 1'b1);
		push_num(32'd1000000000, 1'b1);
		push_num(-32'd1000000000, 1'b1);
		wait_idle();

		// Random batches, one capacity each; idling pattern follows progress.
		while (n_formatted + n_dropped < TARGET_ITEMS) begin
			if (n_formatted + n_dropped < 110) begin
				send_idle = 34;
				recv_idle = 47;
			end else if (n_formatted + n_dropped < 220) begin
				send_idle = 47;
				recv_idle = 34;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			cap = caps[batch % 10];
			// long lists on big buffers so they still reach overflow
			start_pct = (cap < 100) ? 20 : 3;
			set_capacity(cap);
			for (int i = 0; i < BATCH_LEN; i++)
				push_num(pick_value(), (i == 0) || ($urandom_range(99, 0) < start_pct));
			wait_idle();
			batch++;
		end

		if (char_q.size() != 0) begin
			$display("%0d predicted beats never arrived", char_q.size());
			n_bad += char_q.size();
		end
		$display("covered %0d numbers formatted, %0d swallowed, %0d overflow beats",
			n_formatted, n_dropped, n_overflows);
		$display("checked %0d character beats over %0d buffer_size settings",
			n_chars, n_settings);
		if (n_bad == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
hdl/itd_pkg.sv
hdl/itd_dabble.sv
hdl/int_list_to_decimal_text.sv
hdl/itd_checker.sv
sim/tb_top.sv
